// ----- rtl/lbh_pkg.sv -----
// Shared types and constants for the letter bigram histogram.
// Used by lbh_front, lbh_fifo, lbh_back and letter_bigram_histogram_core.
package lbh_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int NUM_LETTERS = 26;
    localparam int NUM_PAIRS   = NUM_LETTERS * NUM_LETTERS;
    localparam int ADDR_W      = $clog2(NUM_PAIRS);
    localparam int LETTER_W    = 5;
    localparam int BYTE_W      = 8;
    localparam int RESULT_W    = 16;

    // command queue between front and back; depth is a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7A;  // 'z'
    localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5A;  // 'Z'

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_INC,        // bump one pair counter
        CMD_READ,       // report one pair counter
        CMD_READ_NONE   // report zero, letter index out of range
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    // queue side of the link between front and back
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

// ----- rtl/letter_bigram_histogram_core.sv -----
// Letter bigram histogram: 26 x 26 saturating pair counters over a byte stream.
// Reset: synchronous; after reset a clearing pass zeroes the counter RAM, one
//   entry a cycle, while the slave side is held not ready.
// Scan words are taken whenever the command queue has room; each letter pair and
//   each read goes through the back end as a RAM read, then a write or result load
//   on the single RAM port; a read waits there until the result word is free.
module letter_bigram_histogram_core
    import lbh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // char_byte[7:0], first_letter[12:8],
                                         // second_letter[17:13], zero pad
    input  logic        i_s_axis_tuser,  // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // pair_count[15:0], count_saturated[16],
                                         // zero pad
);

    t_q_status           q_status;
    t_cmd                push_cmd;
    t_cmd                head_cmd;
    logic                push;
    logic                pop;
    logic                clear_done;
    logic [RESULT_W-1:0] pair_count;
    logic                count_saturated;

    lbh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_opcode        (i_s_axis_tuser),
        .i_char_byte     (i_s_axis_tdata[7:0]),
        .i_first_letter  (i_s_axis_tdata[12:8]),
        .i_second_letter (i_s_axis_tdata[17:13]),
        .i_q_status      (q_status),
        .i_clear_done    (clear_done),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    lbh_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    lbh_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_status        (q_status),
        .i_cmd             (head_cmd),
        .o_pop             (pop),
        .o_clear_done      (clear_done),
        .o_out_valid       (o_m_axis_tvalid),
        .i_out_ready       (i_m_axis_tready),
        .o_pair_count      (pair_count),
        .o_count_saturated (count_saturated)
    );

    assign o_m_axis_tdata = {7'b0, count_saturated, pair_count};

endmodule

// ----- rtl/lbh_front.sv -----
// Front end: accepts stream words, decodes letters, tracks the previous letter
// and turns pairs and reads into counter commands. Depends on lbh_pkg.
module lbh_front
    import lbh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [BYTE_W-1:0]   i_char_byte,
    input  logic [LETTER_W-1:0] i_first_letter,
    input  logic [LETTER_W-1:0] i_second_letter,
    input  t_q_status           i_q_status,
    input  logic                i_clear_done,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic                r_prev_is_letter;
    logic [LETTER_W-1:0] r_prev_idx;
    logic                n_prev_is_letter;
    logic [LETTER_W-1:0] n_prev_idx;

    logic                accept;
    logic                is_lower;
    logic                is_upper;
    logic                is_letter;
    logic [LETTER_W-1:0] cur_idx;
    logic                query_ok;

    assign o_ready = i_clear_done & ~i_q_status.full;
    assign accept  = i_valid & o_ready;

    assign is_lower  = (i_char_byte >= CHAR_LOW_A) && (i_char_byte <= CHAR_LOW_Z);
    assign is_upper  = (i_char_byte >= CHAR_UP_A) && (i_char_byte <= CHAR_UP_Z);
    assign is_letter = is_lower | is_upper;

    always_comb begin
        if (is_lower) begin
            cur_idx = LETTER_W'(i_char_byte - CHAR_LOW_A);
        end else begin
            cur_idx = LETTER_W'(i_char_byte - CHAR_UP_A);
        end
    end

    assign query_ok = (i_first_letter < LETTER_W'(NUM_LETTERS))
                   && (i_second_letter < LETTER_W'(NUM_LETTERS));

    always_comb begin
        n_prev_is_letter = r_prev_is_letter;
        n_prev_idx       = r_prev_idx;
        o_push           = 1'b0;
        o_cmd.kind       = CMD_INC;
        o_cmd.addr       = ADDR_W'(r_prev_idx) * ADDR_W'(NUM_LETTERS) + ADDR_W'(cur_idx);
        if (accept) begin
            unique case (t_opcode'(i_opcode))
                OP_SCAN: begin
                    n_prev_is_letter = is_letter;
                    if (is_letter) begin
                        n_prev_idx = cur_idx;
                        o_push     = r_prev_is_letter;
                    end
                end
                OP_READ: begin
                    // a read leaves the pairing state alone
                    o_push     = 1'b1;
                    o_cmd.kind = query_ok ? CMD_READ : CMD_READ_NONE;
                    o_cmd.addr = ADDR_W'(i_first_letter) * ADDR_W'(NUM_LETTERS)
                               + ADDR_W'(i_second_letter);
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_is_letter <= 1'b0;
            r_prev_idx       <= '0;
        end else begin
            r_prev_is_letter <= n_prev_is_letter;
            r_prev_idx       <= n_prev_idx;
        end
    end

endmodule

// ----- rtl/lbh_fifo.sv -----
// Short command queue between the front end and the counter back end.
// Depends on lbh_pkg for the command type and depth.
module lbh_fifo
    import lbh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push        = i_push & ~o_status.full;
    assign do_pop         = i_pop & o_status.valid;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

// ----- rtl/lbh_back.sv -----
// Back end: owns the pair counter RAM, clears it after reset, performs
// saturating increments and reads, and holds the result word. Depends on lbh_pkg.
module lbh_back
    import lbh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_status           i_q_status,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_clear_done,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [RESULT_W-1:0] o_pair_count,
    output logic                o_count_saturated
);

    logic [COUNT_BITS-1:0] r_mem [NUM_PAIRS];

    t_back_state           r_state;
    t_back_state           n_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    t_cmd                  r_cmd;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_out_valid;
    logic [RESULT_W-1:0]   r_out_count;
    logic                  r_out_sat;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic                  out_load;
    logic                  rd_sat;
    logic [31:0]           rd_wide;
    logic [RESULT_W-1:0]   rd_clip;

    assign rd_sat  = (r_rd_data == COUNT_MAX);
    assign rd_wide = 32'(r_rd_data);
    assign rd_clip = (rd_wide > 32'(16'hFFFF)) ? 16'hFFFF : rd_wide[RESULT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == ADDR_W'(NUM_PAIRS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_status.valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (r_cmd.kind == CMD_INC || !r_out_valid || i_out_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_cmd.addr;
        mem_wdata = rd_sat ? r_rd_data : COUNT_BITS'(r_rd_data + 1'b1);
        out_load  = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            BK_IDLE: begin
                o_pop  = i_q_status.valid;
                mem_re = i_q_status.valid;
            end
            BK_EXEC: begin
                if (r_cmd.kind == CMD_INC) begin
                    mem_we = 1'b1;
                end else begin
                    out_load = !r_out_valid || i_out_ready;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // single-port counter RAM, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_load) begin
            if (r_cmd.kind == CMD_READ) begin
                r_out_count <= rd_clip;
                r_out_sat   <= rd_sat;
            end else begin
                r_out_count <= '0;
                r_out_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_clear_done      = (r_state != BK_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_pair_count      = r_out_count;
    assign o_count_saturated = r_out_sat;

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for letter_bigram_histogram_core: streams text and read words,
// tracks the pair counts alongside the block and checks every returned count.
// Depends on lbh_pkg and letter_bigram_histogram_core.
module tb_top;
    import lbh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_opcode             op;
        logic [BYTE_W-1:0]   chr;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        bit                  wait_drain;  // hold back until all counts are back
        bit                  no_gap;      // offer without random idling
    } t_text_word;

    typedef struct {
        logic [RESULT_W-1:0] count;
        logic                sat;
    } t_pair_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;

    letter_bigram_histogram_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_text_word   text_words[$];
    t_pair_result pending_counts[$];
    int           fail_cnt = 0;
    int           results_seen = 0;
    int           sink_hold_left = 0;
    bit           sink_hold_done = 1'b0;

    // shadow of the block's pairing state and counter table
    bit                    last_was_letter = 1'b0;
    logic [LETTER_W-1:0]   last_letter = '0;
    logic [COUNT_BITS-1:0] pair_tally [NUM_PAIRS] = '{default: '0};

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit letter_of_byte(input logic [BYTE_W-1:0] b,
                                          output logic [LETTER_W-1:0] idx);
        idx = '0;
        if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
            idx = LETTER_W'(b - CHAR_LOW_A);
            return 1'b1;
        end
        if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
            idx = LETTER_W'(b - CHAR_UP_A);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the shadow state by one accepted word; reads queue their count
    task automatic tally_word(input t_text_word w);
        logic [LETTER_W-1:0] cur;
        int                  slot;
        logic [31:0]         wide;
        t_pair_result        res;
        if (w.op == OP_SCAN) begin
            if (!letter_of_byte(w.chr, cur)) begin
                last_was_letter = 1'b0;
            end else begin
                if (last_was_letter) begin
                    slot = int'(last_letter) * NUM_LETTERS + int'(cur);
                    if (pair_tally[slot] != COUNT_MAX)
                        pair_tally[slot] = pair_tally[slot] + 1'b1;
                end
                last_was_letter = 1'b1;
                last_letter = cur;
            end
        end else begin
            res.count = '0;
            res.sat = 1'b0;
            if (w.first < NUM_LETTERS && w.second < NUM_LETTERS) begin
                slot = int'(w.first) * NUM_LETTERS + int'(w.second);
                wide = 32'(pair_tally[slot]);
                res.count = (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
                res.sat = (pair_tally[slot] == COUNT_MAX);
            end
            pending_counts.push_back(res);
        end
    endtask

    function automatic t_text_word make_scan(input logic [BYTE_W-1:0] b);
        t_text_word w;
        w.op = OP_SCAN;
        w.chr = b;
        w.first = LETTER_W'($urandom_range(31));
        w.second = LETTER_W'($urandom_range(31));
        w.wait_drain = 1'b0;
        w.no_gap = 1'b0;
        return w;
    endfunction

    function automatic t_text_word make_read(input int a, input int b);
        t_text_word w;
        w.op = OP_READ;
        w.chr = BYTE_W'($urandom_range(255));
        w.first = LETTER_W'(a);
        w.second = LETTER_W'(b);
        w.wait_drain = 1'b0;
        w.no_gap = 1'b0;
        return w;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_words.push_back(make_scan(s[i]));
    endtask

    function automatic logic [BYTE_W-1:0] letter_byte(input int idx);
        return ($urandom_range(1) != 0) ? CHAR_UP_A + BYTE_W'(idx) : CHAR_LOW_A + BYTE_W'(idx);
    endfunction

    // sender: words stay on the bus until taken
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready)
                tally_word(text_words.pop_front());
            if (!s_tvalid || o_s_axis_tready) begin
                offer = 1'b0;
                if (text_words.size() != 0) begin
                    if (text_words[0].wait_drain && pending_counts.size() != 0)
                        offer = 1'b0;
                    else if (text_words[0].no_gap)
                        offer = 1'b1;
                    else
                        offer = ($urandom_range(99) >= 32);
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {6'b0, text_words[0].second, text_words[0].first,
                                text_words[0].chr};
                    s_tuser <= text_words[0].op;
                end
            end
        end
    end

    // receiver: checks each count word against the oldest expectation
    always @(posedge i_clk) begin
        t_pair_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (pending_counts.size() == 0) begin
                    $error("unexpected result word %h", o_m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = pending_counts.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.count) begin
                        $error("pair_count: expected %0d, got %0d",
                               want.count, o_m_axis_tdata[15:0]);
                        fail_cnt++;
                    end
                    if (o_m_axis_tdata[16] !== want.sat) begin
                        $error("count_saturated: expected %0b, got %0b",
                               want.sat, o_m_axis_tdata[16]);
                        fail_cnt++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (sink_hold_left != 0)
                m_tready <= 1'b0;
            else if (results_seen >= 150 && results_seen < 250)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 32);
        end
    end

    // one long receiver stall so the command queue backs up into the input
    always @(posedge i_clk) begin
        if (!sink_hold_done && results_seen >= 60) begin
            sink_hold_left <= 400;
            sink_hold_done <= 1'b1;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    initial begin
        t_text_word w;
        int         roll;
        int         a;
        int         b;

        // empty table, including out-of-range letter indexes
        text_words.push_back(make_read(0, 0));
        text_words.push_back(make_read(25, 25));
        text_words.push_back(make_read(26, 0));
        text_words.push_back(make_read(0, 31));
        text_words.push_back(make_read(31, 26));
        // mixed case pair, then bytes just outside both letter ranges
        push_text("Ab@A[a`z{Z");
        push_text("zA");
        push_text("\n");
        text_words.push_back(make_scan(8'hC1));
        text_words.push_back(make_scan(8'hE1));
        text_words.push_back(make_scan(8'hFF));
        // pair split by a read
        push_text("q");
        text_words.push_back(make_read(16, 20));
        push_text("u");
        text_words.push_back(make_read(16, 20));
        text_words.push_back(make_read(0, 1));
        text_words.push_back(make_read(25, 0));
        text_words.push_back(make_read(25, 25));

        // the same pair over and over, back to back, on one counter
        w = make_scan(8'h0A);
        w.wait_drain = 1'b1;
        text_words.push_back(w);
        for (int i = 0; i < 64; i++) begin
            w = make_scan((i % 2 != 0) ? CHAR_UP_A : CHAR_LOW_A);
            w.no_gap = 1'b1;
            text_words.push_back(w);
        end
        text_words.push_back(make_read(0, 0));
        text_words.push_back(make_scan(CHAR_LOW_A));
        text_words.push_back(make_read(0, 0));
        push_text("aAa");
        text_words.push_back(make_read(0, 0));

        // random text with reads; a small alphabet most of the time so counts grow
        for (int i = 0; i < 1550; i++) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
                roll = $urandom_range(99);
                if (roll < 60) begin
                    a = $urandom_range(4);
                    b = $urandom_range(4);
                end else if (roll < 85) begin
                    a = $urandom_range(25);
                    b = $urandom_range(25);
                end else begin
                    a = $urandom_range(31);
                    b = $urandom_range(31);
                end
                w = make_read(a, b);
            end else if (roll < 80) begin
                a = ($urandom_range(1) != 0) ? $urandom_range(4) : $urandom_range(25);
                w = make_scan(letter_byte(a));
            end else if (roll < 90) begin
                case ($urandom_range(3))
                    0: w = make_scan(8'h20);
                    1: w = make_scan(8'h0A);
                    2: w = make_scan(8'h2E);
                    default: w = make_scan(8'h2C);
                endcase
            end else begin
                w = make_scan(BYTE_W'($urandom_range(255)));
            end
            w.wait_drain = (i == 0 || i == 1200);
            w.no_gap = (i >= 800 && i < 1000);
            text_words.push_back(w);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_words.size() != 0 || pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lbh_pkg.sv
rtl/lbh_front.sv
rtl/lbh_fifo.sv
rtl/lbh_back.sv
rtl/letter_bigram_histogram_core.sv
test/tb_top.sv
